/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk; ASSERT_CLK is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fba assertion failed");

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("fba assertion failed");

`endif

/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  // Default geometry
  localparam int NUM_BLOCKS_DEF  = 16;
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int NUM_BLOCKS_MAX  = 64;

  // Word field widths
  localparam int CMD_W    = 1;
  localparam int SIZE_W   = 11;
  localparam int START_W  = 8;
  localparam int STATUS_W = 3;
  localparam int FIRST_W  = 4;
  localparam int COUNT_W  = 6;
  localparam int MAP_W    = 16;

  // Job fields sized for the largest supported block count
  localparam int IDX_MAX_W = $clog2(NUM_BLOCKS_MAX);
  localparam int LEN_MAX_W = $clog2(NUM_BLOCKS_MAX + 1);

  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_ZERO_SIZE    = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_BAD_INDEX    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } fba_status_t;

  // Job kinds after classification
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_ZERO,
    OP_NO_SPACE,
    OP_BAD_INDEX
  } fba_op_t;

  typedef struct packed {
    fba_op_t                op;
    logic [IDX_MAX_W-1:0]   idx;
    logic [LEN_MAX_W-1:0]   len;
    logic [COUNT_W-1:0]     count;
  } fba_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CLEAR,
    BK_DONE
  } fba_bk_state_t;

endpackage

`default_nettype wire

/* rtl/fba_req_if.sv */
// ----------------------------------------------------------------------------
// fba_req_if
// Request channel: command, byte size and start block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fba_req_if;
  import fba_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SIZE_W-1:0]  size_bytes;
  logic [START_W-1:0] free_start;

  modport source (output valid, output cmd, output size_bytes, output free_start,
                  input ready);
  modport sink   (input valid, input cmd, input size_bytes, input free_start,
                  output ready);
endinterface

`default_nettype wire

/* rtl/fba_rsp_if.sv */
// ----------------------------------------------------------------------------
// fba_rsp_if
// Response channel: status, first block, block count and usage map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fba_rsp_if;
  import fba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIRST_W-1:0]  first_block;
  logic [COUNT_W-1:0]  block_count;
  logic [MAP_W-1:0]    usage_map;

  modport source (output valid, output status, output first_block, output block_count,
                  output usage_map, input ready);
  modport sink   (input valid, input status, input first_block, input block_count,
                  input usage_map, output ready);
endinterface

`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit contiguous block allocator over a usage bitmap.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req      in   cmd, size_bytes, free_start
//  rsp      out  status, first_block, block_count, usage_map
//
//  Flow: the front multiplies in its stage register and classifies the job
//  into the queue; the engine pops it. Allocate scans the bitmap one block
//  per cycle, then loads the result; free clears the run block by block;
//  rejected words and empty runs go straight to the result register.
//  The bit-serial scan bounds throughput; front and engine are overlapped
//  through a 2-deep queue, so new words are taken while the engine works.
//  Reset clears the bitmap; no words are taken during reset.
//  A stalled rsp holds its word; req is still taken while the queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int NUM_BLOCKS  = fba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fba_pkg::BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fba_req_if.sink   req,
  fba_rsp_if.source rsp
);
  import fba_pkg::*;

  logic     push_valid;
  logic     push_ready;
  fba_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  fba_job_t pop_job;

  fba_front #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  fba_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  fba_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* rtl/fba_queue.sv */
// ----------------------------------------------------------------------------
// fba_queue
// Small job queue that decouples the classifier from the bitmap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_queue #(
  parameter int DEPTH = fba_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  fba_pkg::fba_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fba_pkg::fba_job_t pop_job
);
  import fba_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fba_job_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* rtl/fba_front.sv */
// ----------------------------------------------------------------------------
// fba_front
// Takes request words, rounds the size to blocks and classifies the job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_front #(
  parameter int NUM_BLOCKS  = fba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fba_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fba_req_if.sink           req,
  output logic              push_valid,
  input  logic              push_ready,
  output fba_pkg::fba_job_t push_job
);
  import fba_pkg::*;

  // Ceiling division by a reciprocal: exact for every rounded size below 2**ADD_W
  localparam int ADD_W       = $clog2((1 << SIZE_W) - 1 + BLOCK_BYTES);
  localparam int RECIP_SHIFT = ADD_W + $clog2(BLOCK_BYTES);
  localparam longint unsigned RECIP_MULT =
    ((64'd1 << RECIP_SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam int MULT_W      = $clog2(RECIP_MULT + 1);
  localparam int PROD_W      = ADD_W + MULT_W;
  localparam int CMP_W       = SIZE_W + 1;

  logic               stg_valid;
  logic [CMD_W-1:0]   stg_cmd;
  logic [START_W-1:0] stg_start;
  logic [PROD_W-1:0]  stg_prod;
  logic [ADD_W-1:0]   size_round;
  logic               accept;
  logic               push_fire;
  logic [SIZE_W-1:0]  need;
  logic [CMP_W-1:0]   need_c;
  logic [CMP_W-1:0]   blocks_c;
  logic [CMP_W-1:0]   start_c;
  logic [CMP_W-1:0]   room_c;

  assign size_round = ADD_W'(req.size_bytes) + ADD_W'(BLOCK_BYTES - 1);
  assign accept     = req.valid && req.ready;
  assign push_fire  = push_valid && push_ready;
  assign req.ready  = !rst && (!stg_valid || push_ready);
  assign push_valid = stg_valid;

  // Stage register holds the word and the reciprocal product
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (push_fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_cmd   <= req.cmd;
      stg_start <= req.free_start;
      stg_prod  <= PROD_W'(size_round) * PROD_W'(RECIP_MULT);
    end
  end

  // Block count and run bounds
  assign need     = SIZE_W'(stg_prod >> RECIP_SHIFT);
  assign need_c   = CMP_W'(need);
  assign blocks_c = CMP_W'(NUM_BLOCKS);
  assign start_c  = CMP_W'(stg_start);
  assign room_c   = blocks_c - start_c;

  // Classify the job
  always_comb begin
    push_job       = '0;
    push_job.op    = OP_ZERO;
    push_job.count = COUNT_W'(need);
    if (stg_cmd == CMD_FREE) begin
      if (start_c >= blocks_c) begin
        push_job.op = OP_BAD_INDEX;
      end else begin
        push_job.op  = OP_FREE;
        push_job.idx = IDX_MAX_W'(stg_start);
        // a run past the last block is clipped there
        push_job.len = LEN_MAX_W'((need_c < room_c) ? need_c : room_c);
      end
    end else begin
      if (need == '0) begin
        push_job.op = OP_ZERO;
      end else if (need_c > blocks_c) begin
        push_job.op = OP_NO_SPACE;
      end else begin
        push_job.op  = OP_ALLOC;
        push_job.len = LEN_MAX_W'(need);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fba_back.sv */
// ----------------------------------------------------------------------------
// fba_back
// Bitmap engine: bit-serial first-fit scan and run release, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_back #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  fba_pkg::fba_job_t pop_job,
  fba_rsp_if.source         rsp
);
  import fba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

  fba_bk_state_t        state, state_next;
  logic [NUM_BLOCKS-1:0] bitmap, bitmap_next;
  logic [IDX_W-1:0]     pos, pos_next;
  logic [CNT_W-1:0]     run, run_next;
  logic [IDX_W-1:0]     run_start, run_start_next;
  logic [CNT_W-1:0]     left, left_next;
  logic [CNT_W-1:0]     job_len, job_len_next;
  fba_status_t          res_status, res_status_next;
  logic [IDX_W-1:0]     res_first, res_first_next;
  logic [COUNT_W-1:0]   res_count, res_count_next;

  logic                 out_valid;
  fba_status_t          out_status;
  logic [FIRST_W-1:0]   out_first;
  logic [COUNT_W-1:0]   out_count;
  logic [MAP_W-1:0]     out_map;
  logic                 out_load;
  logic                 out_free;

  logic                 cur_used;
  logic                 at_last;
  logic                 scan_hit;
  logic [IDX_W-1:0]     run_start_cur;
  logic [NUM_BLOCKS:0]  len_ones;
  logic [NUM_BLOCKS-1:0] run_mask;

  // Scan helpers
  assign cur_used      = bitmap[pos];
  assign at_last       = (pos == LAST);
  assign scan_hit      = !cur_used && ((run + CNT_W'(1)) == job_len);
  assign run_start_cur = (run == '0) ? pos : run_start;
  assign len_ones      = ((NUM_BLOCKS + 1)'(1) << job_len) - (NUM_BLOCKS + 1)'(1);
  assign run_mask      = NUM_BLOCKS'(len_ones) << run_start_cur;
  assign out_free      = !out_valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          case (pop_job.op)
            OP_ALLOC: state_next = BK_SCAN;
            OP_FREE:  state_next = (pop_job.len == '0) ? BK_DONE : BK_CLEAR;
            default:  state_next = BK_DONE;
          endcase
        end
      end
      BK_SCAN: begin
        if (scan_hit || at_last) begin
          state_next = BK_DONE;
        end
      end
      BK_CLEAR: begin
        if (left == CNT_W'(1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    pop_ready       = 1'b0;
    out_load        = 1'b0;
    bitmap_next     = bitmap;
    pos_next        = pos;
    run_next        = run;
    run_start_next  = run_start;
    left_next       = left;
    job_len_next    = job_len;
    res_status_next = res_status;
    res_first_next  = res_first;
    res_count_next  = res_count;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_len_next   = CNT_W'(pop_job.len);
          left_next      = CNT_W'(pop_job.len);
          pos_next       = (pop_job.op == OP_FREE) ? IDX_W'(pop_job.idx) : '0;
          run_next       = '0;
          res_first_next = '0;
          res_count_next = pop_job.count;
          case (pop_job.op)
            OP_ZERO:      res_status_next = ST_ZERO_SIZE;
            OP_NO_SPACE:  res_status_next = ST_NO_SPACE;
            OP_BAD_INDEX: res_status_next = ST_BAD_INDEX;
            default:      res_status_next = ST_OK;
          endcase
        end
      end
      BK_SCAN: begin
        if (cur_used) begin
          run_next = '0;
        end else begin
          run_next       = run + CNT_W'(1);
          run_start_next = run_start_cur;
        end
        if (scan_hit) begin
          bitmap_next    = bitmap | run_mask;
          res_first_next = run_start_cur;
        end else if (at_last) begin
          res_status_next = ST_NO_SPACE;
        end else begin
          pos_next = pos + IDX_W'(1);
        end
      end
      BK_CLEAR: begin
        // a block found free stays free and flags the result
        if (cur_used) begin
          bitmap_next[pos] = 1'b0;
        end else begin
          res_status_next = ST_ALREADY_FREE;
        end
        left_next = left - CNT_W'(1);
        if (left != CNT_W'(1)) begin
          pos_next = pos + IDX_W'(1);
        end
      end
      BK_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Control state and bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      bitmap <= '0;
    end else begin
      state  <= state_next;
      bitmap <= bitmap_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    run        <= run_next;
    run_start  <= run_start_next;
    left       <= left_next;
    job_len    <= job_len_next;
    res_status <= res_status_next;
    res_first  <= res_first_next;
    res_count  <= res_count_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_first  <= FIRST_W'(res_first);
      out_count  <= res_count;
      out_map    <= MAP_W'(bitmap);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.first_block = out_first;
  assign rsp.block_count = out_count;
  assign rsp.usage_map   = out_map;

endmodule

`default_nettype wire

/* rtl/fba_checker.sv */
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks on the allocator response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [fba_pkg::STATUS_W-1:0]  rsp_status,
  input logic [fba_pkg::FIRST_W-1:0]   rsp_first_block,
  input logic [fba_pkg::COUNT_W-1:0]   rsp_block_count,
  input logic [fba_pkg::MAP_W-1:0]     rsp_usage_map
);
  import fba_pkg::*;

  // A stalled response word holds
  `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_first_block) && $stable(rsp_block_count) && $stable(rsp_usage_map))

  // Nothing is offered right after reset
  `ASSERT_ALWAYS(a_rst_quiet, rst |=> !rsp_valid)

  // A zero-size reject always rounds to no blocks
  `ASSERT_CLK(a_zero_count, rsp_valid && rsp_status == ST_ZERO_SIZE |-> rsp_block_count == '0)

  // Only a good allocation reports a start block
  `ASSERT_CLK(a_fail_first, rsp_valid && rsp_status != ST_OK |-> rsp_first_block == '0)

endmodule

bind first_fit_block_allocator fba_checker u_fba_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_first_block (rsp.first_block),
  .rsp_block_count (rsp.block_count),
  .rsp_usage_map   (rsp.usage_map)
);

`default_nettype wire
